// ===== hdl/lps_pkg.sv =====
// shared types, constants and the sine table for the led pattern sequencer
package lps_pkg;

  // sine table length and derived widths
  localparam int SINE_SAMPLES = 1000;
  localparam int SAMPLE_W     = $clog2(SINE_SAMPLES);
  localparam int QUARTER      = SINE_SAMPLES / 4;
  localparam int FILL_W       = $clog2(SINE_SAMPLES + 2);

  typedef logic [SAMPLE_W-1:0] sidx_t;
  typedef logic [SAMPLE_W:0]   sidx_ext_t;
  typedef logic [FILL_W-1:0]   fill_t;

  // config register map
  localparam int CFG_ADDR_W = 3;
  localparam logic [CFG_ADDR_W-1:0] ADDR_START_SEQ = 3'd0;
  localparam logic [4:0] START_SEQ_RESET = 5'd0;

  // item commands
  localparam logic CMD_TICK   = 1'b0;
  localparam logic CMD_SELECT = 1'b1;

  // pattern codes
  localparam logic [4:0] PAT_FIXED_LAST = 5'd9;
  localparam logic [4:0] PAT_TWINKLE    = 5'd10;
  localparam logic [4:0] PAT_PULSE      = 5'd11;
  localparam logic [4:0] PAT_SINE_FIRST = 5'd12;
  localparam logic [4:0] PAT_SINE_LAST  = 5'd16;

  // pulse pattern timing
  localparam logic [6:0] FRAME_MS = 7'd65;
  localparam logic [7:0] PULSE_HOLD_LEVEL = 8'hff;
  localparam logic [3:0] WRAP_AT [3] = '{4'd12, 4'd11, 4'd10};

  localparam logic [7:0] FIXED_LEVELS [10] =
    '{8'd25, 8'd51, 8'd76, 8'd102, 8'd127, 8'd153, 8'd178, 8'd204, 8'd229, 8'd255};
  localparam logic [6:0] SINE_WAIT [5] = '{7'd10, 7'd8, 7'd6, 7'd4, 7'd2};

  localparam logic [7:0] MIN_LEVEL = 8'd5;

  typedef enum logic [1:0] {
    CLS_ZERO,
    CLS_POS,
    CLS_NEG
  } sample_cls_t;

  typedef struct packed {
    logic       command;
    logic [7:0] sequence_req;
  } item_t;

  typedef struct packed {
    logic [7:0] duty0;
    logic [7:0] duty1;
    logic [7:0] duty2;
    logic [7:0] duty3;
    logic [4:0] active_pattern;
    logic       invalid_select;
  } result_t;

  // half-wave class of a sample index
  function automatic sample_cls_t sample_class(sidx_t k);
    sidx_ext_t k2;
    k2 = {k, 1'b0};
    if (k == '0 || k2 == sidx_ext_t'(SINE_SAMPLES)) begin
      return CLS_ZERO;
    end else if (k2 < sidx_ext_t'(SINE_SAMPLES)) begin
      return CLS_POS;
    end
    return CLS_NEG;
  endfunction

  // two multiplies of the taylor recurrence, q30
  function automatic logic [63:0] taylor_next(logic [63:0] term, logic [63:0] x);
    return (((term * x) >> 30) * x) >> 30;
  endfunction

  // q30 |sin| sample scaled to 255, small levels forced to zero
  function automatic logic [7:0] sine_level(int unsigned k);
    logic [63:0] t;
    logic [63:0] u;
    logic [63:0] x;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] v;
    t = (64'(k) << 32) / 64'(SINE_SAMPLES);
    u = t & 64'h7fff_ffff;
    if (u > 64'h4000_0000) begin
      u = 64'h8000_0000 - u;
    end
    x = (u * 64'd3373259426) >> 31;
    term = x;
    sum  = x;
    term = taylor_next(term, x) / 64'd6;
    sum  = (sum >= term) ? sum - term : 64'd0;
    term = taylor_next(term, x) / 64'd20;
    sum  = sum + term;
    term = taylor_next(term, x) / 64'd42;
    sum  = (sum >= term) ? sum - term : 64'd0;
    term = taylor_next(term, x) / 64'd72;
    sum  = sum + term;
    term = taylor_next(term, x) / 64'd110;
    sum  = (sum >= term) ? sum - term : 64'd0;
    term = taylor_next(term, x) / 64'd156;
    sum  = sum + term;
    term = taylor_next(term, x) / 64'd210;
    sum  = (sum >= term) ? sum - term : 64'd0;
    term = taylor_next(term, x) / 64'd272;
    sum  = sum + term;
    if (sum > 64'h4000_0000 || u == 64'h4000_0000) begin
      sum = 64'h4000_0000;
    end
    v = (64'd255 * sum) >> 30;
    if (v < 64'(MIN_LEVEL)) begin
      return 8'd0;
    end
    return v[7:0];
  endfunction

  typedef logic [7:0] sine_rom_t [SINE_SAMPLES];

  function automatic sine_rom_t build_sine_rom();
    sine_rom_t r;
    int        k;
    for (k = 0; k < SINE_SAMPLES; k++) begin
      r[k] = sine_level(k);
    end
    return r;
  endfunction

  localparam sine_rom_t SINE_ROM = build_sine_rom();

  // samples used at pattern entry
  localparam logic [7:0]  ENTRY_LEVEL_A = SINE_ROM[0];
  localparam logic [7:0]  ENTRY_LEVEL_B = SINE_ROM[QUARTER % SINE_SAMPLES];
  localparam sample_cls_t ENTRY_CLS_A   = sample_class(sidx_t'(0));
  localparam sample_cls_t ENTRY_CLS_B   = sample_class(sidx_t'(QUARTER % SINE_SAMPLES));

endpackage

// ===== hdl/lps_ram.sv =====
// generic ram, one write port, two registered read ports
module lps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
  output logic [WIDTH-1:0]         rd_data_a,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
  output logic [WIDTH-1:0]         rd_data_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_a <= mem[rd_addr_a];
    rd_data_b <= mem[rd_addr_b];
  end

endmodule

// ===== hdl/led_pattern_sequencer_top.sv =====
// led pattern sequencer top level: pattern state, sine table and result buffer
//
// Four 8-bit PWM duties driven by a stream of items. Each item is either a one
// millisecond tick or a pattern select; every accepted item gives exactly one result
// with the duties, the running pattern and an invalid-select flag. Patterns 0-9 hold
// a fixed level, 11 runs 65 ms breathing frames, 12-16 play a |sine| table at one
// sample per 10/8/6/4/2 ticks. An item is taken every clock cycle while item_stall is
// low, and its result is registered into the result register, or into the skid register
// behind a stalled result. A two-entry result buffer (result register plus skid register)
// lets a new item enter while the previous result is still stalled; item_stall rises only
// while the table loads or when both entries are full. After reset the sine table ram is
// loaded from the constant table, one entry a cycle, and item_stall stays high until the
// first read data is ready. The table ram reads the two samples the next sine step will
// need, addressed from the next state, so a step never waits on the memory. start_sequence
// may be written at any time over the apb port and takes effect on the next invalid select.
module led_pattern_sequencer_top (
  input  logic                   clk,
  input  logic                   rst,
  // item channel
  input  logic                   item_valid,
  output logic                   item_stall,
  input  lps_pkg::item_t         item,
  // result channel
  output logic                   result_valid,
  input  logic                   result_stall,
  output lps_pkg::result_t       result,
  // configuration port
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [lps_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  import lps_pkg::*;

  // pattern state
  typedef struct packed {
    logic [4:0]       pattern;
    logic [6:0]       ms;
    sidx_t            idx;
    logic [2:0][3:0]  cnt;
    logic [2:0]       marks;
    logic [3:0][7:0]  level;
  } seq_state_t;

  // frame level for ms m within a pulse frame
  function automatic logic [7:0] pulse_level(logic [6:0] m);
    priority if (m < 7'd5) begin
      return 8'd12;
    end else if (m < 7'd10) begin
      return 8'd24;
    end else if (m < 7'd15) begin
      return 8'd36;
    end else if (m < 7'd20) begin
      return 8'd48;
    end else if (m < 7'd45) begin
      return 8'd64;
    end else if (m < 7'd50) begin
      return 8'd48;
    end else if (m < 7'd55) begin
      return 8'd36;
    end else if (m < 7'd60) begin
      return 8'd24;
    end else if (m < FRAME_MS) begin
      return 8'd12;
    end else begin
      return 8'd0;
    end
  endfunction

  // counters advance or wrap, wrapping marks the channel
  function automatic seq_state_t frame_start(seq_state_t s);
    seq_state_t r;
    int         c;
    r = s;
    r.marks = '0;
    for (c = 0; c < 3; c++) begin
      if (s.cnt[c] >= WRAP_AT[c]) begin
        r.cnt[c]   = '0;
        r.marks[c] = 1'b1;
      end else begin
        r.cnt[c] = s.cnt[c] + 4'd1;
      end
    end
    return r;
  endfunction

  function automatic seq_state_t pulse_apply(seq_state_t s);
    seq_state_t r;
    int         c;
    r = s;
    for (c = 0; c < 3; c++) begin
      r.level[c] = s.marks[c] ? pulse_level(s.ms) : 8'd0;
    end
    r.level[3] = PULSE_HOLD_LEVEL;
    return r;
  endfunction

  // positive half feeds the first channel, negative half the second
  function automatic logic [15:0] feed_pair(logic [7:0] pos_old, logic [7:0] neg_old,
                                            logic [7:0] v, sample_cls_t cls);
    logic [7:0] p;
    logic [7:0] n;
    p = pos_old;
    n = neg_old;
    if (cls != CLS_NEG) begin
      p = v;
    end
    if (cls != CLS_POS) begin
      n = v;
    end
    return {p, n};
  endfunction

  function automatic logic is_sine(logic [4:0] p);
    return p >= PAT_SINE_FIRST && p <= PAT_SINE_LAST;
  endfunction

  // clear state and set time-zero levels of pattern p
  function automatic seq_state_t enter_state(logic [4:0] p);
    seq_state_t  r;
    logic [15:0] pa;
    logic [15:0] pb;
    int          c;
    r = '0;
    r.pattern = p;
    if (p <= PAT_FIXED_LAST) begin
      for (c = 0; c < 4; c++) begin
        r.level[c] = FIXED_LEVELS[p[3:0]];
      end
    end else if (p == PAT_PULSE) begin
      r = frame_start(r);
      r = pulse_apply(r);
    end else if (is_sine(p)) begin
      pa = feed_pair(8'd0, 8'd0, ENTRY_LEVEL_A, ENTRY_CLS_A);
      pb = feed_pair(8'd0, 8'd0, ENTRY_LEVEL_B, ENTRY_CLS_B);
      r.level[0] = pa[15:8];
      r.level[2] = pa[7:0];
      r.level[1] = pb[15:8];
      r.level[3] = pb[7:0];
    end
    return r;
  endfunction

  // one millisecond tick; va/vb are the samples for the next sine step
  function automatic seq_state_t tick_state(seq_state_t s, logic [7:0] va, logic [7:0] vb,
                                            sample_cls_t ca, sample_cls_t cb);
    seq_state_t  r;
    logic [15:0] pa;
    logic [15:0] pb;
    logic [4:0]  off;
    r = s;
    if (s.pattern == PAT_PULSE) begin
      r.ms = s.ms + 7'd1;
      if (r.ms >= FRAME_MS) begin
        r.ms = '0;
        r = frame_start(r);
      end
      r = pulse_apply(r);
    end else if (is_sine(s.pattern)) begin
      off  = s.pattern - PAT_SINE_FIRST;
      r.ms = s.ms + 7'd1;
      if (r.ms >= SINE_WAIT[off[2:0]]) begin
        r.ms  = '0;
        r.idx = (s.idx == sidx_t'(SINE_SAMPLES - 1)) ? '0 : s.idx + 1'b1;
        pa = feed_pair(s.level[0], s.level[2], va, ca);
        pb = feed_pair(s.level[1], s.level[3], vb, cb);
        r.level[0] = pa[15:8];
        r.level[2] = pa[7:0];
        r.level[1] = pb[15:8];
        r.level[3] = pb[7:0];
      end
    end
    return r;
  endfunction

  logic        [4:0] start_sequence;
  seq_state_t        st;
  seq_state_t        st_next;
  logic              invalid_next;
  logic              accept;
  logic              take;
  result_t           res_next;
  result_t           skid;
  logic              skid_valid;

  // sine table load and lookahead reads
  fill_t             fill_count;
  logic              fill_busy;
  logic              fill_wr;
  sidx_t             rd_addr_a;
  sidx_t             rd_addr_b;
  sidx_ext_t         rd_sum_b;
  logic        [7:0] rom_a;
  logic        [7:0] rom_b;
  sample_cls_t       cls_a;
  sample_cls_t       cls_b;

  // configuration port
  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_START_SEQ) ? 32'(start_sequence) : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_sequence <= START_SEQ_RESET;
    end else if (psel && penable && pwrite && paddr == ADDR_START_SEQ) begin
      start_sequence <= pwdata[4:0];
    end
  end

  // handshake: stall only while loading or with both result entries full
  assign item_stall = fill_busy || skid_valid;
  assign accept     = item_valid && !item_stall;
  assign take       = result_valid && !result_stall;

  // next pattern state for the item on the port
  always_comb begin
    st_next      = st;
    invalid_next = 1'b0;
    if (accept) begin
      if (item.command == CMD_TICK) begin
        st_next = tick_state(st, rom_a, rom_b, cls_a, cls_b);
      end else if (item.sequence_req > 8'(PAT_SINE_LAST) ||
                   item.sequence_req == 8'(PAT_TWINKLE)) begin
        // invalid select always restarts the start pattern
        st_next      = enter_state(start_sequence);
        invalid_next = 1'b1;
      end else if (item.sequence_req[4:0] != st.pattern) begin
        st_next = enter_state(item.sequence_req[4:0]);
      end
    end
  end

  always_comb begin
    res_next.duty0          = st_next.level[0];
    res_next.duty1          = st_next.level[1];
    res_next.duty2          = st_next.level[2];
    res_next.duty3          = st_next.level[3];
    res_next.active_pattern = st_next.pattern;
    res_next.invalid_select = invalid_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= enter_state(START_SEQ_RESET);
    end else begin
      st <= st_next;
    end
  end

  // result register plus skid register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else begin
      if (accept) begin
        if (!result_valid || take) begin
          result       <= res_next;
          result_valid <= 1'b1;
        end else begin
          skid       <= res_next;
          skid_valid <= 1'b1;
        end
      end else if (take) begin
        if (skid_valid) begin
          result     <= skid;
          skid_valid <= 1'b0;
        end else begin
          result_valid <= 1'b0;
        end
      end
    end
  end

  // table load sweep, running on past the last write so the first lookahead read lands
  assign fill_busy = fill_count != fill_t'(SINE_SAMPLES + 1);
  assign fill_wr   = fill_count < fill_t'(SINE_SAMPLES);

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
    end else if (fill_busy) begin
      fill_count <= fill_count + 1'b1;
    end
  end

  // lookahead addresses: sample after the next index and its quarter-shifted partner
  always_comb begin
    rd_addr_a = (st_next.idx == sidx_t'(SINE_SAMPLES - 1)) ? '0 : st_next.idx + 1'b1;
    rd_sum_b  = {1'b0, rd_addr_a} + sidx_ext_t'(QUARTER);
    if (rd_sum_b >= sidx_ext_t'(SINE_SAMPLES)) begin
      rd_addr_b = sidx_t'(rd_sum_b - sidx_ext_t'(SINE_SAMPLES));
    end else begin
      rd_addr_b = rd_sum_b[SAMPLE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    cls_a <= sample_class(rd_addr_a);
    cls_b <= sample_class(rd_addr_b);
  end

  lps_ram #(
    .WIDTH (8),
    .DEPTH (SINE_SAMPLES)
  ) u_sine_ram (
    .clk       (clk),
    .wr_en     (fill_wr),
    .wr_addr   (fill_count[SAMPLE_W-1:0]),
    .wr_data   (SINE_ROM[fill_count[SAMPLE_W-1:0]]),
    .rd_addr_a (rd_addr_a),
    .rd_data_a (rom_a),
    .rd_addr_b (rd_addr_b),
    .rd_data_b (rom_b)
  );

  // skid entry only fills behind a waiting result
  a_skid_behind_result: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> result_valid)
    else $error("skid entry held without a result");

  // no item may enter while the table is loading
  a_no_accept_in_fill: assert property (@(posedge clk) disable iff (rst)
    fill_busy |-> !accept)
    else $error("item accepted during table load");

  // pulse frames never run past their length
  a_pulse_ms_bound: assert property (@(posedge clk) disable iff (rst)
    st.pattern == PAT_PULSE |-> st.ms < FRAME_MS)
    else $error("pulse frame counter out of range");

  // pulse pattern holds channel 3 full on
  a_pulse_ch3: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.active_pattern == PAT_PULSE |-> result.duty3 == PULSE_HOLD_LEVEL)
    else $error("channel 3 not held in pulse pattern");

  // sine index stays inside the table
  a_idx_bound: assert property (@(posedge clk) disable iff (rst)
    st.idx < sidx_t'(SINE_SAMPLES))
    else $error("sine index out of range");

endmodule
